>>> src/rmmmv_pkg.sv
// Shared types and constants for the running min/max/mean/variance block.
// Used by rmmmv_lane, running_min_max_mean_variance_top and the checker.
package rmmmv_pkg;

  localparam int MEASURE_COUNT_DEF = 8;
  localparam int TYPE_COUNT_DEF    = 4;
  localparam int MEASURE_FIELDS    = 8;

  localparam int VAL_W = 32;
  localparam int VAR_W = 48;
  localparam int CNT_W = 32;

  localparam logic [VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
  localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic [VAR_W-1:0] VAR_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [CNT_W-1:0] CNT_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [VAL_W-1:0] min_v;
    logic [VAL_W-1:0] max_v;
    logic [VAL_W-1:0] mean_v;
    logic [VAR_W-1:0] var_v;
  } lane_stats_t;

  typedef enum logic [1:0] {
    L_IDLE,
    L_DIV,
    L_MUL,
    L_ACC
  } lane_state_t;

  typedef enum logic [1:0] {
    T_IDLE,
    T_RUN,
    T_EMIT
  } top_state_t;

endpackage

>>> src/running_min_max_mean_variance_top.sv
// Running min/max/mean/variance over event records, one lane per measure.
// After an input beat the block waits until every lane is done (the 48-bit
// variance divider in each lane is the slow step), then one result beat per active measure.
// No new event is taken until the last result beat has gone; receiver stalls hold the
// result beats. ACTIVE = min(MEASURE_COUNT, 8); lanes run in parallel.
// Reset (rst, synchronous): counters clear, minima to max value, maxima to min value.
// Depends on rmmmv_pkg and rmmmv_lane.
module running_min_max_mean_variance_top #(
  parameter int MEASURE_COUNT = rmmmv_pkg::MEASURE_COUNT_DEF,
  parameter int TYPE_COUNT    = rmmmv_pkg::TYPE_COUNT_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [255:0] s_tdata,  // measure_0 .. measure_7, 32 bits each
  input  logic [1:0]   s_tuser,  // event_type
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [207:0] m_tdata,  // running_min, running_max, running_mean,
                                 // running_variance, events_seen, type_events_seen
  output logic [2:0]   m_tuser,  // measure_index
  output logic         m_tlast   // last_result
);

  localparam int ACTIVE = (MEASURE_COUNT < rmmmv_pkg::MEASURE_FIELDS) ?
                          MEASURE_COUNT : rmmmv_pkg::MEASURE_FIELDS;
  localparam int IW  = (ACTIVE > 1) ? $clog2(ACTIVE) : 1;
  localparam int TIW = (TYPE_COUNT > 1) ? $clog2(TYPE_COUNT) : 1;

  rmmmv_pkg::top_state_t state, state_next;

  logic [31:0] event_total;
  logic [31:0] type_counts [TYPE_COUNT];
  logic [31:0] type_seen;
  logic [IW-1:0] out_idx;

  logic                   accept, beat_out, lanes_busy;
  logic [ACTIVE-1:0]      lane_busy;
  rmmmv_pkg::lane_stats_t lane_stats [ACTIVE];
  rmmmv_pkg::lane_stats_t sel;
  logic                   type_ok;
  logic [TIW-1:0]         tidx;
  logic [31:0]            tcnt_inc;

  assign accept     = s_tvalid && s_tready;
  assign beat_out   = m_tvalid && m_tready;
  assign lanes_busy = |lane_busy;

  for (genvar i = 0; i < ACTIVE; i++) begin : g_lane
    rmmmv_lane u_lane (
      .clk(clk), .rst(rst), .start(accept),
      .x(s_tdata[32*i +: 32]), .n(event_total),
      .busy(lane_busy[i]), .stats(lane_stats[i])
    );
  end

  assign type_ok  = {2'b00, s_tuser} < 4'(TYPE_COUNT) || TYPE_COUNT > 4;
  assign tidx     = TIW'(s_tuser);
  assign tcnt_inc = (type_counts[tidx] == rmmmv_pkg::CNT_MAX) ?
                    rmmmv_pkg::CNT_MAX : type_counts[tidx] + 32'd1;

  always_comb begin
    state_next = state;
    case (state)
      rmmmv_pkg::T_IDLE: if (accept) state_next = rmmmv_pkg::T_RUN;
      rmmmv_pkg::T_RUN:  if (!lanes_busy) state_next = rmmmv_pkg::T_EMIT;
      rmmmv_pkg::T_EMIT: if (beat_out && out_idx == IW'(ACTIVE - 1))
                           state_next = rmmmv_pkg::T_IDLE;
      default:           state_next = rmmmv_pkg::T_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    m_tvalid = 1'b0;
    case (state)
      rmmmv_pkg::T_IDLE: s_tready = 1'b1;
      rmmmv_pkg::T_EMIT: m_tvalid = 1'b1;
      default: begin
        s_tready = 1'b0;
        m_tvalid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= rmmmv_pkg::T_IDLE;
      event_total <= '0;
      out_idx     <= '0;
      for (int t = 0; t < TYPE_COUNT; t++) type_counts[t] <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        // lanes latch the count before this event on the same edge
        if (event_total != rmmmv_pkg::CNT_MAX) event_total <= event_total + 32'd1;
        if (type_ok) type_counts[tidx] <= tcnt_inc;
        type_seen <= type_ok ? tcnt_inc : 32'd0;
        out_idx   <= '0;
      end else if (beat_out) begin
        out_idx <= out_idx + IW'(1);
      end
    end
  end

  assign sel     = lane_stats[out_idx];
  assign m_tdata = {type_seen, event_total, sel.var_v, sel.mean_v, sel.max_v, sel.min_v};
  assign m_tuser = 3'(out_idx);
  assign m_tlast = out_idx == IW'(ACTIVE - 1);

endmodule

>>> src/rmmmv_div.sv
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
module rmmmv_div #(
  parameter int NW = 48,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic [NW-1:0] quotient,
  output logic          busy
);

  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] rem;
  logic [DW-1:0] dvs;
  logic [NW-1:0] qsh;
  logic [CW-1:0] cnt;
  logic [DW:0]   trial;
  logic          fits;

  // shift in the next dividend bit, subtract when the divisor fits
  assign trial = {rem, qsh[NW-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(NW);
      rem  <= '0;
      dvs  <= divisor;
      qsh  <= dividend;
    end else if (busy) begin
      rem  <= fits ? DW'(trial - {1'b0, dvs}) : trial[DW-1:0];
      qsh  <= {qsh[NW-2:0], fits};
      cnt  <= cnt - CW'(1);
      busy <= cnt != CW'(1);
    end
  end

  assign quotient = qsh;

endmodule

>>> src/rmmmv_lane.sv
// One measure lane: min/max compare, mean and variance update.
// Depends on rmmmv_pkg and rmmmv_div (one for the mean step, one for var / n).
module rmmmv_lane (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [31:0]             x,
  input  logic [31:0]             n,
  output logic                    busy,
  output rmmmv_pkg::lane_stats_t  stats
);

  rmmmv_pkg::lane_state_t state, state_next;

  logic [31:0] min_v, max_v, mean_v;
  logic [47:0] var_v;
  logic [31:0] n_r;
  logic        neg_r;
  logic [46:0] sq16;
  logic [56:0] p_lo;
  logic [55:0] p_hi;

  logic [32:0] diff, diff_mag, np1_in, np1;
  logic [32:0] mq;
  logic [47:0] vq;
  logic        mbusy, vbusy;
  logic        div_start;
  logic [31:0] q_add;
  logic [63:0] sq_full;
  logic [79:0] prod;
  logic [47:0] inc, kept;
  logic [48:0] sum;

  assign diff     = {x[31], x} - {mean_v[31], mean_v};
  assign diff_mag = diff[32] ? (33'd0 - diff) : diff;
  assign np1_in   = {1'b0, n} + 33'd1;
  assign np1      = {1'b0, n_r} + 33'd1;

  rmmmv_div #(.NW(33), .DW(33)) u_mdiv (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(diff_mag), .divisor(np1_in),
    .quotient(mq), .busy(mbusy)
  );

  rmmmv_div #(.NW(48), .DW(32)) u_vdiv (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(var_v), .divisor(n),
    .quotient(vq), .busy(vbusy)
  );

  // mean quotient magnitude is at most 2^31 whenever the variance is updated
  assign q_add   = neg_r ? (32'd0 - mq[31:0]) : mq[31:0];
  assign sq_full = mq[31:0] * mq[31:0];
  assign prod    = {23'd0, p_lo} + {p_hi, 24'd0};
  assign inc     = (prod > {32'd0, rmmmv_pkg::VAR_MAX}) ? rmmmv_pkg::VAR_MAX : prod[47:0];
  assign kept    = var_v - vq;
  assign sum     = {1'b0, kept} + {1'b0, inc};

  always_comb begin
    state_next = state;
    case (state)
      rmmmv_pkg::L_IDLE: if (start) state_next = rmmmv_pkg::L_DIV;
      rmmmv_pkg::L_DIV:  if (!mbusy && !vbusy) state_next = rmmmv_pkg::L_MUL;
      rmmmv_pkg::L_MUL:  state_next = rmmmv_pkg::L_ACC;
      rmmmv_pkg::L_ACC:  state_next = rmmmv_pkg::L_IDLE;
      default:           state_next = rmmmv_pkg::L_IDLE;
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    busy      = 1'b1;
    case (state)
      rmmmv_pkg::L_IDLE: begin
        div_start = start;
        busy      = 1'b0;
      end
      default: begin
        div_start = 1'b0;
        busy      = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= rmmmv_pkg::L_IDLE;
      min_v  <= rmmmv_pkg::VAL_MAX;
      max_v  <= rmmmv_pkg::VAL_MIN;
      mean_v <= '0;
      var_v  <= '0;
    end else begin
      state <= state_next;
      if (state == rmmmv_pkg::L_IDLE && start) begin
        if ($signed(x) < $signed(min_v)) min_v <= x;
        if ($signed(x) > $signed(max_v)) max_v <= x;
        n_r   <= n;
        neg_r <= diff[32];
      end
      if (state == rmmmv_pkg::L_DIV && !mbusy && !vbusy) begin
        mean_v <= mean_v + q_add;
        sq16   <= sq_full[62:16];
      end
      if (state == rmmmv_pkg::L_MUL) begin
        p_lo <= sq16[23:0] * np1;
        p_hi <= sq16[46:24] * np1;
      end
      if (state == rmmmv_pkg::L_ACC && n_r != 32'd0) begin
        var_v <= sum[48] ? rmmmv_pkg::VAR_MAX : sum[47:0];
      end
    end
  end

  assign stats.min_v  = min_v;
  assign stats.max_v  = max_v;
  assign stats.mean_v = mean_v;
  assign stats.var_v  = var_v;

endmodule

>>> tb/sv/running_min_max_mean_variance_checker.sv
// Checker for running_min_max_mean_variance_top: watches both stream channels,
// predicts the statistics of every event beat and compares each result beat.
// Depends on rmmmv_pkg.
`timescale 1ns / 100ps
module running_min_max_mean_variance_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [255:0] s_tdata,
  input  logic [1:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [207:0] m_tdata,
  input  logic [2:0]   m_tuser,
  input  logic         m_tlast,
  output int           fail_count,
  output int           pending
);

  typedef struct {
    logic [2:0]                  idx;
    logic [rmmmv_pkg::VAL_W-1:0] min_v;
    logic [rmmmv_pkg::VAL_W-1:0] max_v;
    logic [rmmmv_pkg::VAL_W-1:0] mean_v;
    logic [rmmmv_pkg::VAR_W-1:0] var_v;
    logic [rmmmv_pkg::CNT_W-1:0] total;
    logic [rmmmv_pkg::CNT_W-1:0] type_cnt;
    logic                        last;
  } stat_beat_t;

  stat_beat_t expected_stats[$];

  logic signed [31:0] lo_q   [8];
  logic signed [31:0] hi_q   [8];
  logic signed [31:0] avg_q  [8];
  logic [47:0]        var_q  [8];
  logic [31:0]        total_q;
  logic [31:0]        type_q [4];

  assign pending = expected_stats.size();

  task automatic absorb_event(input logic [255:0] data, input logic [1:0] kind);
    logic [63:0] n, keep, sq, inc, sum, mag;
    logic signed [63:0] x, om, nm, dm;
    stat_beat_t b;
    n = {32'd0, total_q};
    for (int m = 0; m < 8; m++) begin
      x = $signed(data[m*32 +: 32]);
      if (x < lo_q[m]) lo_q[m] = x[31:0];
      if (x > hi_q[m]) hi_q[m] = x[31:0];
      om = avg_q[m];
      nm = om + (x - om) / $signed(n + 64'd1);
      avg_q[m] = nm[31:0];
      if (n > 0) begin
        keep = {16'd0, var_q[m]} - {16'd0, var_q[m]} / n;
        dm = nm - om;
        mag = dm < 0 ? -dm : dm;
        sq = (mag * mag) >> 16;
        if (sq != 0 && (n + 1) > 64'hFFFF_FFFF_FFFF / sq) inc = 64'hFFFF_FFFF_FFFF;
        else inc = sq * (n + 1);
        if (inc > 64'hFFFF_FFFF_FFFF) inc = 64'hFFFF_FFFF_FFFF;
        sum = keep + inc;
        var_q[m] = sum > 64'hFFFF_FFFF_FFFF ? rmmmv_pkg::VAR_MAX : sum[47:0];
      end
    end
    if (total_q != rmmmv_pkg::CNT_MAX) total_q++;
    if (type_q[kind] != rmmmv_pkg::CNT_MAX) type_q[kind]++;
    for (int m = 0; m < 8; m++) begin
      b.idx = m[2:0];
      b.min_v = lo_q[m];
      b.max_v = hi_q[m];
      b.mean_v = avg_q[m];
      b.var_v = var_q[m];
      b.total = total_q;
      b.type_cnt = type_q[kind];
      b.last = (m == 7);
      expected_stats = {expected_stats, b};
    end
  endtask

  task automatic compare_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s expected %0h actual %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    stat_beat_t e;
    if (rst) begin
      for (int m = 0; m < 8; m++) begin
        lo_q[m] = rmmmv_pkg::VAL_MAX;
        hi_q[m] = rmmmv_pkg::VAL_MIN;
        avg_q[m] = 0;
        var_q[m] = 0;
      end
      total_q = 0;
      for (int t = 0; t < 4; t++) type_q[t] = 0;
    end else begin
      if (s_tvalid && s_tready) absorb_event(s_tdata, s_tuser);
      if (m_tvalid && m_tready) begin
        if (expected_stats.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count++;
        end else begin
          e = expected_stats.pop_front();
          compare_field("measure_index", e.idx, m_tuser);
          compare_field("running_min", e.min_v, m_tdata[31:0]);
          compare_field("running_max", e.max_v, m_tdata[63:32]);
          compare_field("running_mean", e.mean_v, m_tdata[95:64]);
          compare_field("running_variance", e.var_v, m_tdata[143:96]);
          compare_field("events_seen", e.total, m_tdata[175:144]);
          compare_field("type_events_seen", e.type_cnt, m_tdata[207:176]);
          compare_field("last_result", e.last, m_tlast);
        end
      end
    end
  end

  initial fail_count = 0;
endmodule

>>> tb/sv/running_min_max_mean_variance_top_tb.sv
// Stimulus and verdict for running_min_max_mean_variance_top: directed extreme
// events, then bursty random events against a stalling receiver.
// Depends on running_min_max_mean_variance_top and running_min_max_mean_variance_checker.
`timescale 1ns / 100ps
module running_min_max_mean_variance_top_tb;
  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [255:0] s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [207:0] m_tdata;
  logic [2:0]   m_tuser;
  logic         m_tlast;
  int           fail_count;
  int           pending;

  always #10 clk = ~clk;

  running_min_max_mean_variance_top i_dut (.*);
  running_min_max_mean_variance_checker i_chk (.*);

  // receiver stall pattern: long free runs alternating with random stalls
  always @(negedge clk) begin
    int phase;
    phase = int'(($time / 4000) % 3);
    if (phase == 0) m_tready <= 1'b1;
    else m_tready <= ($urandom_range(0, 3) != 0);
  end

  function automatic logic [31:0] pick_value(input int mode);
    case (mode)
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return $urandom_range(0, 16'hFFFF) - 32'h8000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_event(input logic [1:0] kind, input logic [255:0] data);
    s_tdata <= data;
    s_tuser <= kind;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic rest();
    s_tvalid <= 1'b0;
    repeat ($urandom_range(0, 70)) @(negedge clk);
  endtask

  initial begin
    logic [255:0] d;
    int burst;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // directed: extremes, all-zeros, all-ones and alternating-bit patterns, then mixed values
    for (int k = 0; k < 20; k++) begin
      for (int m = 0; m < 8; m++)
        d[m*32 +: 32] = (k < 3) ? pick_value(k) :
                        (k < 5) ? (k == 3 ? 32'hFFFF_FFFF : 32'h5555_AAAA) :
                        pick_value((k + m) % 5);
      send_event(k[1:0], d);
      if (k % 4 == 3) rest();
    end
    s_tvalid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
    // random bursts
    for (int k = 0; k < 90; ) begin
      burst = int'($urandom_range(1, 6));
      for (int j = 0; j < burst; j++, k++) begin
        for (int m = 0; m < 8; m++)
          d[m*32 +: 32] = pick_value($urandom_range(0, 9) < 6 ? 3 :
                                     int'($urandom_range(0, 4)));
        send_event(2'($urandom_range(0, 3)), d);
      end
      rest();
    end
    s_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (100) @(posedge clk);
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
